FILE: rtl/irt_pkg.sv
`timescale 1ns / 1ps
// irt_pkg: shared types, constants and the alphabet lookup for the radix text block.
// No dependencies.
package irt_pkg;

	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 2 ** DIGIT_W;
	localparam int CHAR_W     = 8;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_BITS  = 8;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

	localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
	localparam logic [CFG_W-1:0]   CHARS_LO_RST = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0]   CHARS_HI_RST = 64'h0000_0000_0000_3938;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIX    = 2'd0,
		CFG_CHARS_LO = 2'd1,
		CFG_CHARS_HI = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic [CFG_W-1:0]   chars_lo;
		logic [CFG_W-1:0]   chars_hi;
	} irt_cfg_t;

	function automatic logic [CHAR_W-1:0] alpha_char(
		input logic [DIGIT_W-1:0] d,
		input logic [CFG_W-1:0]   lo,
		input logic [CFG_W-1:0]   hi
	);
		logic [2*CFG_W-1:0] chars;
		chars = {hi, lo};
		return chars[d*CHAR_W +: CHAR_W];
	endfunction

endpackage

FILE: rtl/irt_fifo.sv
`timescale 1ns / 1ps
// irt_fifo: two-entry queue between the front and back parts.
// No dependencies; the width W is set by the module around it.
module irt_fifo #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en && !full, rd_en && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/irt_front.sv
`timescale 1ns / 1ps
// irt_front: configuration registers, alphabet check, sign and magnitude of each input beat.
// Depends on irt_pkg.
module irt_front #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [irt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irt_pkg::CFG_W-1:0]         cfg_data,
	output irt_pkg::irt_cfg_t                 cfg,
	input  logic                              push,
	output logic                              full,
	input  logic signed [VALUE_BITS-1:0]      value,
	output logic                              q_wr,
	output logic [VALUE_BITS:0]               q_data,
	input  logic                              q_full
);
	import irt_pkg::*;

	irt_cfg_t               cfg_q;
	logic                   alpha_ok;
	logic [CHAR_W-1:0]      ci;
	logic                   neg;
	logic [VALUE_BITS-1:0]  mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix    <= RADIX_RST;
			cfg_q.chars_lo <= CHARS_LO_RST;
			cfg_q.chars_hi <= CHARS_HI_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RADIX:    cfg_q.radix    <= cfg_data[RADIX_W-1:0];
				CFG_CHARS_LO: cfg_q.chars_lo <= cfg_data;
				CFG_CHARS_HI: cfg_q.chars_hi <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// radix range check, no sign characters, and pairwise compare of all active characters
	always_comb begin
		ci       = '0;
		alpha_ok = (cfg_q.radix >= RADIX_W'(2)) && (cfg_q.radix <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < NUM_DIGITS; i++) begin
			ci = alpha_char(DIGIT_W'(i), cfg_q.chars_lo, cfg_q.chars_hi);
			if (RADIX_W'(i) < cfg_q.radix) begin
				if (ci == CH_MINUS || ci == CH_PLUS) begin
					alpha_ok = 1'b0;
				end
				for (int j = 0; j < i; j++) begin
					if (alpha_char(DIGIT_W'(j), cfg_q.chars_lo, cfg_q.chars_hi) == ci) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

	// most negative value wraps to 2^(VALUE_BITS-1), which is its magnitude
	assign neg    = value[VALUE_BITS-1];
	assign mag    = neg ? (~value + VALUE_BITS'(1)) : value;
	assign cfg    = cfg_q;
	assign full   = q_full;
	assign q_wr   = push && !q_full && alpha_ok;
	assign q_data = {neg, mag};

endmodule

FILE: rtl/irt_back.sv
`timescale 1ns / 1ps
// irt_back: digit extraction by iterative division, digit stack and character output register.
// Depends on irt_pkg.
module irt_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  irt_pkg::irt_cfg_t             cfg,
	input  logic                          q_empty,
	output logic                          q_rd,
	input  logic [VALUE_BITS:0]           q_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [irt_pkg::CHAR_W-1:0]    character,
	output logic                          last
);
	import irt_pkg::*;

	localparam int DIV_CYC = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD     = DIV_CYC * STEP_BITS;
	localparam int DCW     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
	localparam int AW      = $clog2(VALUE_BITS);
	localparam int CW      = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 neg_q;
	logic [PAD-1:0]       quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [DCW-1:0]       dcnt_q;
	logic [CW-1:0]        cnt_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	logic [DIGIT_W-1:0]   stack_mem [VALUE_BITS];
	logic [DIGIT_W-1:0]   rd_q;

	logic [PAD-1:0]       quo_v;
	logic [DIGIT_W-1:0]   rem_v;
	logic [RADIX_W-1:0]   t;
	logic                 div_last;
	logic                 slot_free;
	logic                 emit;
	logic                 wr_en;
	logic [AW-1:0]        rd_addr;

	// STEP_BITS restoring steps per cycle
	always_comb begin
		quo_v = quo_q;
		rem_v = rem_q;
		t     = '0;
		for (int k = 0; k < STEP_BITS; k++) begin
			t     = {rem_v, quo_v[PAD-1]};
			quo_v = {quo_v[PAD-2:0], 1'b0};
			if (t >= cfg.radix) begin
				t        = t - cfg.radix;
				quo_v[0] = 1'b1;
			end
			rem_v = t[DIGIT_W-1:0];
		end
	end

	assign div_last  = dcnt_q == DCW'(DIV_CYC - 1);
	assign slot_free = !out_valid_q || pop;
	assign emit      = slot_free && (((state_q == ST_SIGN) && neg_q) || (state_q == ST_EMIT));
	assign wr_en     = (state_q == ST_DIV) && div_last && (cnt_q < CW'(VALUE_BITS));
	assign rd_addr   = AW'(cnt_q - CW'(1));
	assign q_rd      = (state_q == ST_IDLE) && !q_empty;
	assign empty     = !out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[cnt_q[AW-1:0]] <= rem_v;
		end
		rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						neg_q   <= q_data[VALUE_BITS];
						quo_q   <= PAD'(q_data[VALUE_BITS-1:0]);
						rem_q   <= '0;
						dcnt_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_v;
					if (div_last) begin
						dcnt_q <= '0;
						rem_q  <= '0;
						cnt_q  <= cnt_q + CW'(1);
						if (quo_v == '0) begin
							state_q <= ST_SIGN;
						end
					end else begin
						dcnt_q <= dcnt_q + DCW'(1);
						rem_q  <= rem_v;
					end
				end
				ST_SIGN: begin
					if (!neg_q) begin
						state_q <= ST_READ;
					end else if (slot_free) begin
						char_q      <= CH_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						char_q      <= alpha_char(rd_q, cfg.chars_lo, cfg.chars_hi);
						last_q      <= cnt_q == CW'(1);
						cnt_q       <= cnt_q - CW'(1);
						state_q     <= (cnt_q == CW'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// signed_integer_to_radix_text: top level, front part, two-entry queue, back part.
// Depends on irt_pkg, irt_front, irt_fifo, irt_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  input    | push / full          | value
//  result   | pop / empty          | character, last
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// In the back part the divider retires 8 quotient bits a cycle, and each digit is then read
// from the stack memory and emitted once the result slot is free. The front takes a beat
// every cycle until the two-entry queue fills, and queues it only while the alphabet check
// passes. Reset clears the registers but not the queue and stack memories; no clearing pass
// is needed. A stalled result port holds the back part; the front keeps filling the queue.
module signed_integer_to_radix_text #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [VALUE_BITS-1:0]      value,
	output logic                              empty,
	input  logic                              pop,
	output logic [irt_pkg::CHAR_W-1:0]        character,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irt_pkg::CFG_W-1:0]         cfg_data
);
	import irt_pkg::*;

	irt_cfg_t              cfg;
	logic                  q_wr;
	logic [VALUE_BITS:0]   q_wdata;
	logic                  q_full;
	logic                  q_rd;
	logic [VALUE_BITS:0]   q_rdata;
	logic                  q_empty;

	assign cfg_ready = 1'b1;

	irt_front #(
		.MAX_RADIX  (MAX_RADIX),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.value     (value),
		.q_wr      (q_wr),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	irt_fifo #(
		.W (VALUE_BITS + 1)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	irt_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.q_data    (q_rdata),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

endmodule
